### hw/rtl/med7_pkg.sv
// ---------------------------------------------------------------------------
// med7_pkg
// Shared types, constants and key conversion for the seven-tap median filter.
// ---------------------------------------------------------------------------
package med7_pkg;

  localparam int unsigned Taps     = 7;
  localparam int unsigned Center   = 3;
  localparam int unsigned SampleW  = 32;
  localparam int unsigned FlushMax = 4;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [SampleW-1:0] key_t;
  typedef sample_t [Taps-1:0] window_t;
  typedef logic [2:0]         count_t;

  typedef enum logic [0:0] {
    ST_STREAM = 1'b0,
    ST_FLUSH  = 1'b1
  } state_t;

  // Window plus the tag that travels with it into the sorter.
  typedef struct packed {
    window_t win;
    logic    last;
  } med_req_t;

  // Monotone unsigned key for IEEE order; -0 folded onto +0.
  function automatic key_t to_key(input sample_t x);
    sample_t v;
    v = (x == 32'h8000_0000) ? '0 : x;
    return v[SampleW-1] ? ~v : (v | 32'h8000_0000);
  endfunction

  function automatic sample_t from_key(input key_t k);
    return k[SampleW-1] ? (k ^ 32'h8000_0000) : ~k;
  endfunction

endpackage

### hw/rtl/med7_stream_if.sv
// ---------------------------------------------------------------------------
// med7_stream_if
// Valid/ready channel carrying one 32-bit sample and an end-of-run flag.
// ---------------------------------------------------------------------------
interface med7_stream_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  logic        last;

  modport source (output valid, output data, output last, input ready);
  modport sink   (input valid, input data, input last, output ready);
endinterface

### hw/rtl/med7_window.sv
// ---------------------------------------------------------------------------
// med7_window
// Window shift register and run control; replays the last sample to flush.
// ---------------------------------------------------------------------------
module med7_window import med7_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  sample_t  in_sample,
  input  logic     in_final,
  output logic     in_ready,
  output logic     req_valid,
  output med_req_t req,
  input  logic     advance
);

  window_t win;
  window_t win_next;
  count_t  seen_count;
  count_t  seen_count_next;
  state_t  state;
  state_t  state_next;
  logic [1:0] flush_left;
  logic [1:0] flush_left_next;
  logic       req_valid_next;
  logic       req_last;
  logic       req_last_next;
  logic       take;
  // Number of flush steps that produce a result (run length, max 3).
  logic [1:0] run_extra;
  logic [1:0] run_extra_next;

  assign in_ready = (state == ST_STREAM) && advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    state_next      = state;
    win_next        = win;
    seen_count_next = seen_count;
    flush_left_next = flush_left;
    req_valid_next  = req_valid && !advance;
    req_last_next   = req_last;
    unique case (state)
      ST_STREAM: begin
        if (take) begin
          if (seen_count == '0) begin
            win_next = {Taps{in_sample}};
          end else begin
            win_next = {in_sample, win[Taps-1:1]};
          end
          if (in_final) begin
            // centres inside the run: min(len,4); first emitted now if len>=4
            seen_count_next = '0;
            req_valid_next  = (seen_count == count_t'(3)) || (seen_count == count_t'(4));
            req_last_next   = 1'b0;
            flush_left_next = 2'd3;
            state_next      = ST_FLUSH;
          end else begin
            if (seen_count != count_t'(FlushMax)) begin
              seen_count_next = seen_count + count_t'(1);
            end
            req_valid_next = (seen_count == count_t'(3)) || (seen_count == count_t'(4));
            req_last_next  = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        if (advance) begin
          win_next        = {win[Taps-1], win[Taps-1:1]};
          flush_left_next = flush_left - 2'd1;
          // skip centres before the run start: window replicas make centre
          // equal win[0]; emit only when the centre sample was a real one
          req_valid_next  = (flush_left <= run_extra);
          req_last_next   = (flush_left == 2'd1);
          if (flush_left == 2'd1) begin
            state_next = ST_STREAM;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    run_extra_next = run_extra;
    if (take && in_final) begin
      run_extra_next = (seen_count >= count_t'(2)) ? 2'd3 : (seen_count[1:0] + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_STREAM;
      seen_count <= '0;
      flush_left <= '0;
      run_extra  <= '0;
      req_valid  <= 1'b0;
      win        <= '0;
    end else begin
      state      <= state_next;
      seen_count <= seen_count_next;
      flush_left <= flush_left_next;
      run_extra  <= run_extra_next;
      req_valid  <= req_valid_next;
      win        <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      req_last <= req_last_next;
    end
  end

  assign req = '{win: win, last: req_last};

endmodule

### hw/rtl/med7_sorter.sv
// ---------------------------------------------------------------------------
// med7_sorter
// Selection network picking the centre key of seven; result register.
// ---------------------------------------------------------------------------
module med7_sorter import med7_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  med_req_t req,
  output logic     advance,
  output logic     out_valid,
  output sample_t  out_data,
  output logic     out_last,
  input  logic     out_ready
);

  key_t    k   [Taps];
  sample_t med;

  // rank count: element i is the median if 3 others lie below it (ties by index)
  always_comb begin
    logic [2:0] below [Taps];
    med = '0;
    for (int i = 0; i < Taps; i++) begin
      k[i] = to_key(req.win[i]);
    end
    for (int i = 0; i < Taps; i++) begin
      below[i] = '0;
      for (int j = 0; j < Taps; j++) begin
        if (j != i) begin
          if ((k[j] < k[i]) || ((k[j] == k[i]) && (j < i))) begin
            below[i] = below[i] + 3'd1;
          end
        end
      end
    end
    for (int i = 0; i < Taps; i++) begin
      if (below[i] == 3'(Center)) begin
        med = from_key(k[i]);
      end
    end
  end

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= med;
      out_last <= req.last;
    end
  end

endmodule

### hw/rtl/median7_stream_filter.sv
// ---------------------------------------------------------------------------
// median7_stream_filter
// Seven-tap median over runs of IEEE-754 single samples, edge replicated.
// ---------------------------------------------------------------------------
// Latency: a result passes through the window register and then the result register.
// Throughput: one sample per cycle while out is not blocked; after a final
//   sample in.ready is low while the window replays the last sample to flush.
// Reset (rst, synchronous): empties the window, clears the run count and
//   drops any pending result.
module median7_stream_filter import med7_pkg::*; (
  input logic         clk,
  input logic         rst,
  med7_stream_if.sink   in,
  med7_stream_if.source out
);

  // window stage -> sorter/result register
  logic     req_valid;
  med_req_t req;
  logic     advance;

  med7_window u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_sample (in.data),
    .in_final  (in.last),
    .in_ready  (in.ready),
    .req_valid (req_valid),
    .req       (req),
    .advance   (advance)
  );

  // result register stalls both stages together when out is blocked
  med7_sorter u_sorter (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .advance   (advance),
    .out_valid (out.valid),
    .out_data  (out.data),
    .out_last  (out.last),
    .out_ready (out.ready)
  );

endmodule
